[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds on every clock edge while not in reset.
`define CHECK_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks the property at every clock edge, reset cycles included.
`define CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/lbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types and constants for the linear branch entropy profiler.
// ----------------------------------------------------------------------------
package lbe_pkg;
   localparam int ADDR_BITS_DEF  = 8;
   localparam int HIST_BITS_DEF  = 4;
   localparam int COUNT_BITS_DEF = 32;
   localparam int SUM_BITS       = 48;
   localparam int Q_BITS         = 17;
   localparam int ADDR_W         = 64;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam logic KIND_BRANCH = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic report;
      logic taken;
      logic [15:0] addr;
   } cmd_type;
endpackage

[design/lbe_ram.sv]
// ----------------------------------------------------------------------------
// lbe_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

[design/lbe_queue.sv]
// ----------------------------------------------------------------------------
// lbe_queue
// Short command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lbe_queue
   import lbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    not_empty
);
   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_PTR_BITS:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

   `CHECK_PROP(a_no_overflow, clock, reset, !(push && full), "push into full queue")
   `CHECK_PROP(a_no_underflow, clock, reset, !(pop && !not_empty), "pop from empty queue")
   `CHECK_PROP(a_cnt_range, clock, reset, cnt_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH),
      "queue count out of range")
endmodule

[design/lbe_engine.sv]
// ----------------------------------------------------------------------------
// lbe_engine
// Back end: clears the tables after reset, updates counters for branch items,
// walks the tables and divides for report items, holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lbe_engine
   import lbe_pkg::*;
#(
   parameter int ADDR_BITS  = ADDR_BITS_DEF,
   parameter int HIST_BITS  = HIST_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             head_cmd,
   input  logic                not_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SUM_BITS-1:0] rsp_total_branches,
   output logic [SUM_BITS-1:0] rsp_minority_sum,
   output logic [Q_BITS-1:0]   rsp_entropy_q16,
   output logic                rsp_empty_res
);
   localparam int IDX_BITS = ADDR_BITS + HIST_BITS;
   localparam int DEPTH    = 1 << IDX_BITS;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [SUM_BITS-1:0]   SUM_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [2:0]            st_ff, st_in;
   logic [IDX_BITS:0]     ptr_ff, ptr_in;
   logic [HIST_BITS-1:0]  hist_ff, hist_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  tk_ff, tk_in;
   logic                  rdv_ff, rdv_in;
   logic [SUM_BITS-1:0]   tot_ff, tot_in, min_ff, min_in;
   logic [SUM_BITS:0]     rem_ff, rem_in;
   logic [Q_BITS-1:0]     q_ff, q_in;
   logic [4:0]            step_ff, step_in;
   logic                  vld_ff, vld_in;
   logic [SUM_BITS-1:0]   otot_ff, otot_in, omin_ff, omin_in;
   logic [Q_BITS-1:0]     oq_ff, oq_in;
   logic                  oemp_ff, oemp_in;

   logic                  we;
   logic [IDX_BITS-1:0]   waddr, raddr;
   logic [COUNT_BITS-1:0] wt, wn, rt, rn;
   logic [SUM_BITS:0]     pair, tsum, msum, rsh;
   logic [COUNT_BITS-1:0] mn;

   lbe_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_taken (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wt),
      .rd_addr(raddr), .rd_data_ff(rt));
   lbe_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_not_taken (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wn),
      .rd_addr(raddr), .rd_data_ff(rn));

   assign rsp_valid          = vld_ff;
   assign rsp_total_branches = otot_ff;
   assign rsp_minority_sum   = omin_ff;
   assign rsp_entropy_q16    = oq_ff;
   assign rsp_empty_res      = oemp_ff;

   always_comb begin
      st_in   = st_ff;
      ptr_in  = ptr_ff;
      hist_in = hist_ff;
      idx_in  = idx_ff;
      tk_in   = tk_ff;
      rdv_in  = 1'b0;
      tot_in  = tot_ff;
      min_in  = min_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      vld_in  = vld_ff && rsp_stall;
      otot_in = otot_ff;
      omin_in = omin_ff;
      oq_in   = oq_ff;
      oemp_in = oemp_ff;
      pop     = 1'b0;
      we      = 1'b0;
      waddr   = idx_ff;
      wt      = rt;
      wn      = rn;
      raddr   = idx_ff;
      mn      = (rt < rn) ? rt : rn;
      pair    = (SUM_BITS+1)'(rt) + (SUM_BITS+1)'(rn);
      if (pair > (SUM_BITS+1)'(SUM_MAX)) pair = (SUM_BITS+1)'(SUM_MAX);
      tsum    = (SUM_BITS+1)'(tot_ff) + pair;
      msum    = (SUM_BITS+1)'(min_ff) + (SUM_BITS+1)'(mn);
      rsh     = {rem_ff[SUM_BITS-1:0], 1'b0};
      unique case (st_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = ptr_ff[IDX_BITS-1:0];
            wt    = '0;
            wn    = '0;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == (IDX_BITS+1)'(DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               if (head_cmd.report == KIND_REPORT) begin
                  if (!vld_ff || !rsp_stall) begin
                     ptr_in = '0;
                     tot_in = '0;
                     min_in = '0;
                     st_in  = ST_WALK;
                  end else begin
                     pop = 1'b0;
                  end
               end else begin
                  idx_in  = {head_cmd.addr[ADDR_BITS-1:0], hist_ff};
                  raddr   = {head_cmd.addr[ADDR_BITS-1:0], hist_ff};
                  tk_in   = head_cmd.taken;
                  hist_in = HIST_BITS'({hist_ff, head_cmd.taken});
                  st_in   = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            we = 1'b1;
            if (tk_ff) begin
               wt = (rt == CNT_MAX) ? rt : rt + 1'b1;
            end else begin
               wn = (rn == CNT_MAX) ? rn : rn + 1'b1;
            end
            st_in = ST_IDLE;
         end
         ST_WALK: begin
            raddr = ptr_ff[IDX_BITS-1:0];
            if (ptr_ff != (IDX_BITS+1)'(DEPTH)) ptr_in = ptr_ff + 1'b1;
            rdv_in = (ptr_ff != (IDX_BITS+1)'(DEPTH));
            if (rdv_ff) begin
               tot_in = (tsum > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX : tsum[SUM_BITS-1:0];
               min_in = (msum > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX : msum[SUM_BITS-1:0];
            end
            if (!rdv_ff && ptr_ff == (IDX_BITS+1)'(DEPTH)) begin
               rem_in  = (SUM_BITS+1)'(min_ff);
               q_in    = '0;
               step_in = '0;
               st_in   = ST_DIV;
               if (min_ff >= tot_ff) begin
                  q_in    = Q_BITS'(65536);
                  step_in = 5'(Q_BITS);
               end
            end
         end
         ST_DIV: begin
            if (step_ff == 5'(Q_BITS) || tot_ff == '0) begin
               st_in = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
               if (rsh >= (SUM_BITS+1)'(tot_ff)) begin
                  rem_in = rsh - (SUM_BITS+1)'(tot_ff);
                  q_in   = {q_ff[Q_BITS-2:0], 1'b1};
               end else begin
                  rem_in = rsh;
                  q_in   = {q_ff[Q_BITS-2:0], 1'b0};
               end
            end
         end
         ST_OUT: begin
            vld_in  = 1'b1;
            otot_in = tot_ff;
            omin_in = min_ff;
            oemp_in = (tot_ff == '0);
            oq_in   = (tot_ff == '0) ? '0 :
                      (q_ff > Q_BITS'(65536)) ? Q_BITS'(65536) : q_ff;
            st_in   = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_CLEAR;
         ptr_ff  <= '0;
         hist_ff <= '0;
         rdv_ff  <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         ptr_ff  <= ptr_in;
         hist_ff <= hist_in;
         rdv_ff  <= rdv_in;
         vld_ff  <= vld_in;
      end
      idx_ff  <= idx_in;
      tk_ff   <= tk_in;
      tot_ff  <= tot_in;
      min_ff  <= min_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      otot_ff <= otot_in;
      omin_ff <= omin_in;
      oq_ff   <= oq_in;
      oemp_ff <= oemp_in;
   end

   `CHECK_PROP(a_out_only_idle, clock, reset, (st_ff == ST_OUT) |-> (!vld_ff || !rsp_stall),
      "result overwritten while stalled")
   `CHECK_PROP(a_empty_zero, clock, reset, (vld_ff && oemp_ff) |-> (oq_ff == '0),
      "empty result with nonzero entropy")
   `CHECK_PROP(a_pop_idle, clock, reset, pop |-> (st_ff == ST_IDLE), "pop outside idle")
endmodule

[design/lbe_front.sv]
// ----------------------------------------------------------------------------
// lbe_front
// Front end: accepts request items, classifies them and pushes commands.
// ----------------------------------------------------------------------------
module lbe_front
   import lbe_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [ADDR_W-1:0] req_branch_addr,
   input  logic              req_taken,
   input  logic              full,
   output logic              push,
   output cmd_type           push_cmd
);
   assign req_stall       = full;
   assign push            = req_valid && !full;
   assign push_cmd.report = (req_kind == KIND_REPORT);
   assign push_cmd.taken  = req_taken & (req_kind == KIND_BRANCH);
   assign push_cmd.addr   = req_branch_addr[15:0];
endmodule

[design/linear_branch_entropy_profiler_top.sv]
// ----------------------------------------------------------------------------
// linear_branch_entropy_profiler_top
// Branch outcome table with saturating counters and a linear entropy report.
//
//   channel | direction | handshake          | fields
//   req     | in        | req_valid/stall    | kind, branch_addr, taken
//   rsp     | out       | rsp_valid/stall    | total_branches, minority_sum,
//           |           |                    | entropy_q16, empty_res
//
// After reset the tables are cleared entry by entry before the engine takes
// any item. The engine handles a branch item as a RAM read, then a write back.
// A report is popped, the tables are walked and summed, the minority sum is
// divided by a nonzero total, and the result is registered for rsp.
// A 4-entry queue keeps req open while the engine works; req stalls only
// when it is full.
// ----------------------------------------------------------------------------
module linear_branch_entropy_profiler_top
   import lbe_pkg::*;
#(
   parameter int ADDR_BITS  = ADDR_BITS_DEF,
   parameter int HIST_BITS  = HIST_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [ADDR_W-1:0]   req_branch_addr,
   input  logic                req_taken,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SUM_BITS-1:0] rsp_total_branches,
   output logic [SUM_BITS-1:0] rsp_minority_sum,
   output logic [Q_BITS-1:0]   rsp_entropy_q16,
   output logic                rsp_empty_res
);
   logic    full, push, pop, not_empty;
   cmd_type push_cmd, head_cmd;

   lbe_front u_front (
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_branch_addr(req_branch_addr), .req_taken(req_taken),
      .full(full), .push(push), .push_cmd(push_cmd));

   lbe_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .full(full), .pop(pop), .head_cmd(head_cmd), .not_empty(not_empty));

   lbe_engine #(.ADDR_BITS(ADDR_BITS), .HIST_BITS(HIST_BITS),
                .COUNT_BITS(COUNT_BITS)) u_engine (
      .clock(clock), .reset(reset), .head_cmd(head_cmd), .not_empty(not_empty),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_total_branches(rsp_total_branches), .rsp_minority_sum(rsp_minority_sum),
      .rsp_entropy_q16(rsp_entropy_q16), .rsp_empty_res(rsp_empty_res));
endmodule

[tb/sv/linear_branch_entropy_profiler_top_test.sv]
// ----------------------------------------------------------------------------
// linear_branch_entropy_profiler_top_test
// Self-checking testbench for the branch entropy profiler. Branch and report
// items are sent through the req channel while a local copy of the counter
// tables and outcome history predicts every report. Each rsp item is checked
// field by field against the oldest pending prediction. The run covers idle
// and stall phases, a long rsp hold-off behind which a report waits in the
// input queue, and drains between phases.
// ----------------------------------------------------------------------------
module linear_branch_entropy_profiler_top_test;
   import lbe_pkg::*;

   localparam int IDX_BITS  = ADDR_BITS_DEF + HIST_BITS_DEF;
   localparam int DEPTH     = 1 << IDX_BITS;
   localparam int LIMIT     = 30_000_000;
   localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX = '1;
   localparam logic [SUM_BITS-1:0]       SUM_MAX = '1;
   localparam logic [Q_BITS-1:0]         Q_ONE   = 17'd65536;

   typedef struct packed {
      logic [SUM_BITS-1:0] total;
      logic [SUM_BITS-1:0] minority;
      logic [Q_BITS-1:0]   entropy;
      logic                empty;
   } report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_BRANCH;
   logic [ADDR_W-1:0]   req_branch_addr = '0;
   logic                req_taken = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SUM_BITS-1:0] rsp_total_branches;
   logic [SUM_BITS-1:0] rsp_minority_sum;
   logic [Q_BITS-1:0]   rsp_entropy_q16;
   logic                rsp_empty_res;

   logic [COUNT_BITS_DEF-1:0] taken_tbl [DEPTH];
   logic [COUNT_BITS_DEF-1:0] not_taken_tbl [DEPTH];
   logic [HIST_BITS_DEF-1:0]  outcome_hist = '0;
   report_type                pending_reports[$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  errors = 0;
   int  branches_sent = 0;
   int  reports_sent = 0;
   int  reports_seen = 0;
   int  cycles = 0;
   int  hold_left = 0;
   bit  hold_kick = 1'b0;
   bit  hold_seen = 1'b0;

   linear_branch_entropy_profiler_top u_dut (.*);

   always #6 clock = ~clock;

   function automatic logic [SUM_BITS-1:0] sat_sum(logic [SUM_BITS-1:0] a,
                                                   logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = a + b;
      return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
   endfunction

   function automatic report_type predict_report();
      report_type r;
      logic [SUM_BITS-1:0] t, n;
      logic [127:0] q;
      r = '0;
      for (int i = 0; i < DEPTH; i++) begin
         t = taken_tbl[i];
         n = not_taken_tbl[i];
         r.total    = sat_sum(r.total, sat_sum(t, n));
         r.minority = sat_sum(r.minority, (t < n) ? t : n);
      end
      if (r.total == 0) begin
         r.empty = 1'b1;
      end else begin
         q = ({80'd0, r.minority} << 17) / {80'd0, r.total};
         r.entropy = (q > 128'(Q_ONE)) ? Q_ONE : q[Q_BITS-1:0];
      end
      return r;
   endfunction

   task automatic send_item(logic kind, logic [ADDR_W-1:0] addr, logic tk);
      logic [IDX_BITS-1:0] idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_branch_addr <= addr;
      req_taken       <= tk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_REPORT) begin
         pending_reports.push_back(predict_report());
         reports_sent++;
      end else begin
         idx = {addr[ADDR_BITS_DEF-1:0], outcome_hist};
         if (tk) begin
            if (taken_tbl[idx] != CNT_MAX) taken_tbl[idx]++;
         end else begin
            if (not_taken_tbl[idx] != CNT_MAX) not_taken_tbl[idx]++;
         end
         outcome_hist = {outcome_hist[HIST_BITS_DEF-2:0], tk};
         branches_sent++;
      end
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      go_quiet();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {$urandom, $urandom};
   endfunction

   task automatic test_empty_report();
      send_item(KIND_REPORT, '1, 1'b1);
      send_item(KIND_REPORT, '0, 1'b0);
      drain();
   endtask

   task automatic test_directed_extremes();
      send_item(KIND_BRANCH, '0, 1'b0);
      send_item(KIND_BRANCH, '0, 1'b1);
      send_item(KIND_BRANCH, '1, 1'b1);
      send_item(KIND_BRANCH, '1, 1'b0);
      send_item(KIND_BRANCH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_item(KIND_BRANCH, 64'h5555_5555_5555_5555, 1'b0);
      send_item(KIND_REPORT, rand_addr(), 1'b1);
      for (int i = 0; i < 8; i++) send_item(KIND_BRANCH, 64'h0000_0000_0000_0042, 1'b1);
      send_item(KIND_REPORT, rand_addr(), 1'b0);
      for (int i = 0; i < 6; i++) send_item(KIND_BRANCH, 64'hFFFF_0000_0000_0042, i[0]);
      send_item(KIND_REPORT, '1, 1'b1);
      drain();
   endtask

   task automatic random_burst(int n);
      logic [ADDR_W-1:0] pool [8];
      int bias [8];
      int k;
      for (int i = 0; i < 8; i++) begin
         pool[i] = rand_addr();
         bias[i] = $urandom_range(100);
      end
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(7);
         if ($urandom_range(39) == 0)
            send_item(KIND_REPORT, rand_addr(), 1'($urandom_range(1)));
         else if ($urandom_range(9) == 0)
            send_item(KIND_BRANCH, rand_addr(), 1'($urandom_range(1)));
         else
            send_item(KIND_BRANCH, pool[k], $urandom_range(99) < bias[k]);
      end
      send_item(KIND_REPORT, rand_addr(), 1'($urandom_range(1)));
   endtask

   task automatic test_random_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      random_burst(n);
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(KIND_REPORT, rand_addr(), 1'b0);
      hold_kick = ~hold_kick;
      for (int i = 0; i < 40; i++) send_item(KIND_BRANCH, rand_addr(), 1'($urandom_range(1)));
      send_item(KIND_REPORT, rand_addr(), 1'b1);
      drain();
   endtask

   // rsp side: random stall plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= 6000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      report_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result total=%0d", $time, rsp_total_branches);
            errors++;
         end else begin
            exp_r = pending_reports.pop_front();
            reports_seen++;
            if (rsp_total_branches !== exp_r.total) begin
               $display("%0t: total exp %0d got %0d", $time, exp_r.total,
                        rsp_total_branches);
               errors++;
            end
            if (rsp_minority_sum !== exp_r.minority) begin
               $display("%0t: minority exp %0d got %0d", $time, exp_r.minority,
                        rsp_minority_sum);
               errors++;
            end
            if (rsp_entropy_q16 !== exp_r.entropy) begin
               $display("%0t: entropy exp %0d got %0d", $time, exp_r.entropy,
                        rsp_entropy_q16);
               errors++;
            end
            if (rsp_empty_res !== exp_r.empty) begin
               $display("%0t: empty exp %0b got %0b", $time, exp_r.empty, rsp_empty_res);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         taken_tbl[i]     = '0;
         not_taken_tbl[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_report();
      test_directed_extremes();
      test_backpressure();
      test_random_phase(350, 0, 0);
      test_random_phase(350, 59, 0);
      test_random_phase(350, 0, 59);
      test_random_phase(350, 16, 16);
      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d branch items and %0d reports (%0d checked)",
               branches_sent, reports_sent, reports_seen);
      $display("phases: empty table, extremes, rsp hold-off, idle and stall mixes");
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
